// File: sv/crc16fc_pkg.sv
// Shared types, constants and the per-byte CRC-16/MODBUS update for the frame checker.
// No dependencies; imported by every module of crc16_frame_checker.
package crc16fc_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int CRC_SPAN    = 10;
    localparam int POS_W       = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_DATA_W  = 24;

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CRC_LIMIT = POS_W'(CRC_SPAN);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HDR_HI  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR_LO  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SRC     = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DEST    = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CMD     = POS_W'(5);
    localparam logic [POS_W-1:0] POS_TAIL_HI = POS_W'(8);
    localparam logic [POS_W-1:0] POS_TAIL_LO = POS_W'(9);
    localparam logic [POS_W-1:0] POS_CRC_HI  = POS_W'(10);
    localparam logic [POS_W-1:0] POS_CRC_LO  = POS_W'(11);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_WORD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_WORD   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_ID     = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_HEADER = 3'd1,
        ST_DEST   = 3'd2,
        ST_TAIL   = 3'd3,
        ST_CRC    = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] header_word;
        logic [15:0] tail_word;
        logic [7:0]  own_id;
        logic [7:0]  main_id;
    } cfg_t;

    typedef struct packed {
        logic [7:0] command_code;
        logic       command_valid;
        logic [7:0] source_id;
        status_t    status;
        logic       frame_ok;
    } result_t;

    // One byte of reflected CRC-16 (poly 0xA001), LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: sv/crc16_frame_checker.sv
// Top level of the CRC-16/MODBUS fixed 12-byte frame checker.
// Depends on crc16fc_pkg, crc16fc_in_reg, crc16fc_core and crc16fc_out_reg.
//
// Usage:
//  - Slave stream: one frame byte per transfer in s_tdata, s_tuser high on
//    byte 0 of each frame. Bytes outside a frame are dropped; a start flag in
//    mid-frame drops the partial frame and begins a new one.
//  - Master stream: one verdict per complete frame, after byte 11.
//  - Config channel: cfg_index 0 header word, 1 tail word, 2 own id,
//    3 main id; other indexes are ignored. cfg_ready is always high.
//    Write only while no frame is in flight.
// Timing:
//  - One byte per cycle sustained unless a closing byte finds the result
//    register full. A byte is registered in the input register and is
//    processed there; the verdict is loaded into the result register as the
//    closing byte moves on, and m_tvalid is that register's valid flag.
//  - The CRC update is one unrolled byte step between the two registers.
// Reset: aresetn (sync, active low) empties both registers, returns the
//  frame tracker to idle and clears all configuration to zero.
// Stall: while m_tready is low the held verdict stays put; bytes keep
//  flowing until a second verdict is due, then s_tready drops.
module crc16_frame_checker
    import crc16fc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] frame_start
    // Master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] frame_ok, [3:1] status, [11:4] source_id, [12] command_valid,
    // [20:13] command_code, [23:21] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    logic    item_valid;
    logic [7:0] item_byte;
    logic    item_start;
    logic    ends_frame;
    logic    res_ready;
    logic    advance;
    result_t core_result;
    result_t out_result;

    // Register file
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_HEADER_WORD: cfg_next.header_word = cfg_data;
                CFG_TAIL_WORD:   cfg_next.tail_word   = cfg_data;
                CFG_OWN_ID:      cfg_next.own_id      = cfg_data[7:0];
                CFG_MAIN_ID:     cfg_next.main_id     = cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Held byte moves on unless it closes a frame and the result slot is full
    assign advance = item_valid & (~ends_frame | res_ready);

    crc16fc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_byte     (s_tdata),
        .s_start    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_start (item_start)
    );

    crc16fc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .take       (advance),
        .item_byte  (item_byte),
        .item_start (item_start),
        .ends_frame (ends_frame),
        .result     (core_result)
    );

    crc16fc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (advance & ends_frame),
        .res_data  (core_result),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (out_result)
    );

    assign m_tdata = {3'b000,
                      out_result.command_code,
                      out_result.command_valid,
                      out_result.source_id,
                      out_result.status,
                      out_result.frame_ok};

endmodule

// File: sv/crc16fc_in_reg.sv
// Input register of the frame checker: one byte plus its start flag.
// Depends on crc16fc_pkg.
module crc16fc_in_reg
    import crc16fc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_byte,
    input  logic       s_start,
    input  logic       advance,      // held item consumed this cycle
    output logic       item_valid,
    output logic [7:0] item_byte,
    output logic       item_start
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       load;

    assign s_tready   = ~valid_reg | advance;
    assign load       = s_tvalid & s_tready;
    assign valid_next = load | (valid_reg & ~advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= s_byte;
            start_reg <= s_start;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_start = start_reg;

endmodule

// File: sv/crc16fc_core.sv
// Frame state, running CRC and the ordered header/destination/tail/CRC checks.
// Depends on crc16fc_pkg.
module crc16fc_core
    import crc16fc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       take,          // process the held item this cycle
    input  logic [7:0] item_byte,
    input  logic       item_start,
    output logic       ends_frame,    // held item would close a frame
    output result_t    result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    status_t          err_reg, err_next;
    logic [7:0]       high_reg, high_next;
    logic [7:0]       src_reg, src_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [15:0]      crc_final_reg, crc_final_next;

    logic [POS_W-1:0] pos_eff;
    logic             active;
    logic [15:0]      crc_base;
    status_t          err_base;
    logic [15:0]      word;
    logic             ok;
    logic             cmd;

    assign pos_eff    = item_start ? POS_HDR_HI : pos_reg;
    assign active     = item_start | (pos_reg != POS_HDR_HI);
    assign crc_base   = item_start ? CRC_INIT : crc_reg;
    assign err_base   = item_start ? ST_OK : err_reg;
    assign word       = {high_reg, item_byte};
    assign ends_frame = active & (pos_eff == LAST_POS);

    always_comb begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        err_next       = err_reg;
        high_next      = high_reg;
        src_next       = src_reg;
        cmd_next       = cmd_reg;
        crc_final_next = crc_final_reg;
        if (take && active) begin
            crc_next = (pos_eff < CRC_LIMIT) ? crc_byte(crc_base, item_byte) : crc_base;
            err_next = err_base;
            case (pos_eff)
                POS_HDR_HI, POS_TAIL_HI: begin
                    high_next = item_byte;
                end
                POS_HDR_LO: begin
                    if (word != cfg.header_word && err_base == ST_OK) err_next = ST_HEADER;
                end
                POS_SRC: begin
                    src_next = item_byte;
                end
                POS_DEST: begin
                    if (item_byte != cfg.own_id && err_base == ST_OK) err_next = ST_DEST;
                end
                POS_CMD: begin
                    cmd_next = item_byte;
                end
                POS_TAIL_LO: begin
                    if (word != cfg.tail_word && err_base == ST_OK) err_next = ST_TAIL;
                end
                POS_CRC_HI: begin
                    high_next      = item_byte;
                    crc_final_next = crc_base;
                end
                POS_CRC_LO: begin
                    if (word != crc_final_reg && err_base == ST_OK) err_next = ST_CRC;
                end
                default: begin
                end
            endcase
            pos_next = (pos_eff == LAST_POS) ? POS_HDR_HI : pos_eff + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HDR_HI;
            crc_reg <= CRC_INIT;
            err_reg <= ST_OK;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        high_reg      <= high_next;
        src_reg       <= src_next;
        cmd_reg       <= cmd_next;
        crc_final_reg <= crc_final_next;
    end

    // Verdict for the closing byte; err_next already includes the CRC check
    assign ok  = (err_next == ST_OK);
    assign cmd = ok & (src_reg == cfg.main_id);

    always_comb begin
        result.frame_ok      = ok;
        result.status        = err_next;
        result.source_id     = src_reg;
        result.command_valid = cmd;
        result.command_code  = cmd ? cmd_reg : 8'h00;
    end

endmodule

// File: sv/crc16fc_out_reg.sv
// Result register of the frame checker, drives the master stream side.
// Depends on crc16fc_pkg.
module crc16fc_out_reg
    import crc16fc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    input  result_t res_data,
    output logic    res_ready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    assign res_ready  = ~valid_reg | m_tready;
    assign load       = res_valid & res_ready;
    assign valid_next = load | (valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_data   = data_reg;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for crc16_frame_checker: byte-stream driver, verdict monitor
// and a byte-level frame predictor. Depends on crc16fc_pkg and the crc16_frame_checker RTL.
module tb_top;
    import crc16fc_pkg::*;

    // ------------------------------------------------------------------
    // Run knobs
    // ------------------------------------------------------------------
    // Bytes of counted stimulus per random phase (8 phases, ~1450 in total
    // together with the directed and pressure parts).
    localparam int PHASE_BYTES   = 150;
    localparam int PHASES        = 8;
    // The verdict passes the input and result registers after the closing byte;
    // give it some slack before touching config or ending the run.
    localparam int TAIL_CYCLES   = 8;
    // Receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES   = 300;
    // Cycles without any transfer before giving up. The longest legal quiet
    // stretch is the hold-off above plus a few sender gaps.
    localparam int QUIET_LIMIT   = 4000;
    // Index outside the register map; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hFF;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } rx_byte_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    crc16_frame_checker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    rx_byte_t byte_q[$];          // bytes waiting for the driver
    result_t  verdict_q[$];       // verdicts predicted, not yet seen
    int       bytes_queued  = 0;  // written only by the stimulus process
    int       bytes_taken   = 0;  // written only by the driver
    int       src_idle_pct  = 0;
    int       snk_stall_pct = 0;
    logic     pressure_go   = 1'b0;
    logic     hold_off      = 1'b0;
    int       err_cnt       = 0;
    int       verdicts_seen = 0;
    int       cmd_hits      = 0;
    int       status_hits [8];
    int       quiet_cycles  = 0;
    rx_byte_t pend_byte;

    // Predictor copy of the register file (reset values)
    logic [15:0] cfg_header = '0;
    logic [15:0] cfg_tail   = '0;
    logic [7:0]  cfg_own    = '0;
    logic [7:0]  cfg_main   = '0;

    // Predictor copy of the frame tracker
    logic [POS_W-1:0] frame_pos = '0;      // 0 = waiting for a start flag
    logic [15:0]      crc_acc   = CRC_INIT;
    status_t          err_code  = ST_OK;   // first failing check of this frame
    logic [7:0]       hi_byte   = '0;      // high half of a word being assembled
    logic [7:0]       src_byte  = '0;
    logic [7:0]       cmd_byte  = '0;
    logic [15:0]      crc_snap  = '0;      // CRC over bytes 0..9

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Reflected CRC-16, one data bit per iteration, LSB first.
    function automatic logic [15:0] modbus_crc_update(input logic [15:0] acc,
                                                      input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ data[i];
            r  = {1'b0, r[15:1]};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Advance the frame tracker by one accepted byte; on the closing byte
    // push the verdict that the block must produce.
    task automatic take_byte(input logic [7:0] b, input logic start);
        logic [POS_W-1:0] pos;
        logic [15:0]      word;
        result_t          v;
        if (start) begin
            frame_pos = '0;
            crc_acc   = CRC_INIT;
            err_code  = ST_OK;
        end
        // Bytes outside a frame are dropped
        if (start || frame_pos != '0) begin
            pos  = frame_pos;
            word = {hi_byte, b};
            if (pos < CRC_LIMIT) begin
                crc_acc = modbus_crc_update(crc_acc, b);
            end
            case (pos)
                POS_HDR_HI, POS_TAIL_HI: begin
                    hi_byte = b;
                end
                POS_HDR_LO: begin
                    if (word != cfg_header && err_code == ST_OK) err_code = ST_HEADER;
                end
                POS_SRC: begin
                    src_byte = b;
                end
                POS_DEST: begin
                    if (b != cfg_own && err_code == ST_OK) err_code = ST_DEST;
                end
                POS_CMD: begin
                    cmd_byte = b;
                end
                POS_TAIL_LO: begin
                    if (word != cfg_tail && err_code == ST_OK) err_code = ST_TAIL;
                end
                POS_CRC_HI: begin
                    hi_byte  = b;
                    crc_snap = crc_acc;
                end
                POS_CRC_LO: begin
                    if (word != crc_snap && err_code == ST_OK) err_code = ST_CRC;
                end
                default: ;
            endcase
            if (pos != LAST_POS) begin
                frame_pos = pos + 1'b1;
            end else begin
                frame_pos       = '0;
                v.frame_ok      = (err_code == ST_OK);
                v.status        = err_code;
                v.source_id     = src_byte;
                v.command_valid = v.frame_ok && (src_byte == cfg_main);
                v.command_code  = v.command_valid ? cmd_byte : 8'h00;
                verdict_q.push_back(v);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stream driver: one transfer per handshake, random gaps between items
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata, s_tuser);
                bytes_taken++;
            end
            // Load a new byte only when the slot is free or just drained
            if (!s_tvalid || s_tready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    pend_byte = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pend_byte.data;
                    s_tuser  <= pend_byte.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Verdict monitor: compare every accepted transfer with the oldest
    // prediction, field by field
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        err_cnt++;
    endtask

    task automatic check_verdict(input logic [OUT_DATA_W-1:0] bus);
        result_t got;
        result_t want;
        got = result_t'(bus[$bits(result_t)-1:0]);
        verdicts_seen++;
        status_hits[got.status]++;
        if (got.command_valid) cmd_hits++;
        if (verdict_q.size() == 0) begin
            $display("%0t: verdict 0x%0h arrived, expected none", $time, bus);
            err_cnt++;
        end else begin
            want = verdict_q.pop_front();
            if (got.frame_ok != want.frame_ok)
                note_mismatch("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
            if (got.status != want.status)
                note_mismatch("status", 32'(want.status), 32'(got.status));
            if (got.source_id != want.source_id)
                note_mismatch("source_id", 32'(want.source_id), 32'(got.source_id));
            if (got.command_valid != want.command_valid)
                note_mismatch("command_valid", 32'(want.command_valid),
                              32'(got.command_valid));
            if (got.command_code != want.command_code)
                note_mismatch("command_code", 32'(want.command_code),
                              32'(got.command_code));
            if (bus[OUT_DATA_W-1:$bits(result_t)] != '0)
                note_mismatch("pad bits", 0, 32'(bus[OUT_DATA_W-1:$bits(result_t)]));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_verdict(m_tdata);
            end
            m_tready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Long receiver hold-off: the sender keeps offering bytes, so the block
    // must park one verdict, finish the next frame and then stall its input.
    initial begin : receiver_hold
        wait (pressure_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Watchdog: any transfer on any channel counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d verdicts outstanding",
                     $time, quiet_cycles, verdict_q.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // One config transfer; the predictor copy follows on the handshake.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_HEADER_WORD: cfg_header = val;
            CFG_TAIL_WORD:   cfg_tail   = val;
            CFG_OWN_ID:      cfg_own    = val[7:0];
            CFG_MAIN_ID:     cfg_main   = val[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(input logic start, input logic [7:0] data);
        rx_byte_t b;
        b.start = start;
        b.data  = data;
        byte_q.push_back(b);
        bytes_queued++;
    endtask

    // Build a frame against the current register values.
    // faults: [0] header, [1] destination, [2] tail, [3] CRC.
    task automatic queue_frame(input logic [3:0] faults, input logic [7:0] src,
                               input logic [7:0] cmd);
        logic [7:0]  frm [FRAME_BYTES];
        logic [15:0] hdr;
        logic [15:0] tl;
        logic [7:0]  dst;
        logic [15:0] crc;
        hdr = cfg_header;
        tl  = cfg_tail;
        dst = cfg_own;
        if (faults[0]) hdr ^= 16'($urandom_range(1, 16'hFFFF));
        if (faults[1]) dst ^= 8'($urandom_range(1, 8'hFF));
        if (faults[2]) tl  ^= 16'($urandom_range(1, 16'hFFFF));
        frm[0] = hdr[15:8];
        frm[1] = hdr[7:0];
        frm[2] = src;
        frm[3] = dst;
        frm[4] = 8'($urandom);
        frm[5] = cmd;
        frm[6] = 8'($urandom);
        frm[7] = 8'($urandom);
        frm[8] = tl[15:8];
        frm[9] = tl[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) begin
            crc = modbus_crc_update(crc, frm[i]);
        end
        if (faults[3]) crc ^= 16'($urandom_range(1, 16'hFFFF));
        // CRC travels high byte first
        frm[10] = crc[15:8];
        frm[11] = crc[7:0];
        for (int i = 0; i < FRAME_BYTES; i++) begin
            send_byte(i == 0, frm[i]);
        end
    endtask

    // Wait until every byte is taken and every verdict has come back.
    task automatic settle();
        while (bytes_taken != bytes_queued || verdict_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int         counted;
        int         pick;
        int         n;
        logic [3:0] mask;
        logic [7:0] src;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme register values, plus a write to a hole in the map
        write_reg(CFG_HEADER_WORD, 16'hFFFF);
        write_reg(CFG_TAIL_WORD, 16'h0000);
        write_reg(CFG_OWN_ID, 16'h0000);
        write_reg(CFG_MAIN_ID, 16'hFFFF);
        write_reg(CFG_UNUSED_IDX, 16'h5AA5);

        // Stray byte while idle: dropped
        send_byte(1'b0, 8'hFF);
        // Partial frame cut short by a new start flag
        send_byte(1'b1, 8'hFF);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h12);
        // Header, destination and tail all wrong: header must win
        queue_frame(4'b0111, 8'h00, 8'hFF);
        // Clean frame from the main id: command reported
        queue_frame(4'b0000, 8'hFF, 8'h00);
        settle();

        // Back-pressure: receiver stalls long, sender streams back to back
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        pressure_go   = 1'b1;
        repeat (5) queue_frame(4'b0000, cfg_main, 8'($urandom));
        settle();

        for (int p = 0; p < PHASES; p++) begin
            // Idling mix: none, sender gaps, receiver stalls, both
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 51; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 51; end
                default: begin src_idle_pct = 12; snk_stall_pct = 12; end
            endcase

            // Register settings: all ones, all zeros, then random
            if (p == 0) begin
                write_reg(CFG_HEADER_WORD, 16'hFFFF);
                write_reg(CFG_TAIL_WORD, 16'hFFFF);
                write_reg(CFG_OWN_ID, 16'hFFFF);
                write_reg(CFG_MAIN_ID, 16'hFFFF);
            end else if (p == 1) begin
                write_reg(CFG_HEADER_WORD, 16'h0000);
                write_reg(CFG_TAIL_WORD, 16'h0000);
                write_reg(CFG_OWN_ID, 16'h0000);
                write_reg(CFG_MAIN_ID, 16'h0000);
                write_reg(CFG_MAIN_ID + 1'b1, 16'hFFFF);
            end else begin
                write_reg(CFG_HEADER_WORD, 16'($urandom));
                write_reg(CFG_TAIL_WORD, 16'($urandom));
                write_reg(CFG_OWN_ID, 16'($urandom));
                write_reg(CFG_MAIN_ID, 16'($urandom));
                write_reg(CFG_IDX_W'($urandom_range(CFG_MAIN_ID + 1, 255)), 16'($urandom));
            end

            counted = 0;
            while (counted < PHASE_BYTES) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    // Well-formed frame; half clean, the rest with one or
                    // several broken fields
                    n = $urandom_range(99);
                    if (n < 50)      mask = 4'b0000;
                    else if (n < 80) mask = 4'b0001 << $urandom_range(3);
                    else             mask = 4'($urandom_range(1, 15));
                    src = ($urandom_range(1) != 0) ? cfg_main : 8'($urandom);
                    queue_frame(mask, src, 8'($urandom));
                    counted += FRAME_BYTES;
                end else if (pick < 72) begin
                    // Pure noise with a start flag
                    send_byte(1'b1, 8'($urandom));
                    for (int i = 1; i < FRAME_BYTES; i++) send_byte(1'b0, 8'($urandom));
                    counted += FRAME_BYTES;
                end else if (pick < 88) begin
                    // Truncated frame; whatever comes next restarts or extends it
                    n = $urandom_range(1, FRAME_BYTES - 1);
                    send_byte(1'b1, cfg_header[15:8]);
                    for (int i = 1; i < n; i++) send_byte(1'b0, 8'($urandom));
                    counted += n;
                end else begin
                    // Idle-line bytes without a start flag
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) send_byte(1'b0, 8'($urandom));
                end
            end
            // Close the phase on a complete frame so config changes land idle
            queue_frame(4'b0000, cfg_main, 8'($urandom));
            settle();
        end

        $display("Run covered %0d stream bytes and %0d verdicts over %0d config/idling phases",
                 bytes_taken, verdicts_seen, PHASES + 2);
        $display("Verdicts: ok %0d, header %0d, dest %0d, tail %0d, crc %0d, commands %0d",
                 status_hits[ST_OK], status_hits[ST_HEADER], status_hits[ST_DEST],
                 status_hits[ST_TAIL], status_hits[ST_CRC], cmd_hits);
        if (err_cnt == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// File: crc16_frame_checker.f
sv/crc16fc_pkg.sv
sv/crc16fc_in_reg.sv
sv/crc16fc_core.sv
sv/crc16fc_out_reg.sv
sv/crc16_frame_checker.sv
verif/tb_top.sv
